// ===== sv/hcbp_pkg.sv =====
// Package for the Huffman code bit packer: operation codes, queue sizing
// and the command record passed from the front end to the packing back end.
// No dependencies.
package hcbp_pkg;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  localparam int BYTE_BITS = 8;
  localparam int CODE_W    = 32;
  localparam int LEN_W     = 6;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  // One unit of work for the back end: a code to append, or a flush.
  typedef struct packed {
    logic              is_flush;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic room2;
  } q_stat_t;

endpackage

// ===== sv/hcbp_front.sv =====
// Front end of the bit packer: accepts input words, owns the code and length
// tables and turns encode and flush words into commands. Uses hcbp_pkg.
module hcbp_front #(
  parameter int SYMBOLS       = 256,
  parameter int MAX_CODE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [47:0]       in_tdata,
  input  hcbp_pkg::q_stat_t q_stat,
  output logic              push,
  output hcbp_pkg::cmd_t    push_cmd
);

  localparam int AW = $clog2(SYMBOLS);

  logic [1:0]                     op;
  logic [7:0]                     sym;
  logic [31:0]                    word;
  logic [hcbp_pkg::LEN_W-1:0]     len_in;
  logic [hcbp_pkg::LEN_W-1:0]     len_c;
  logic [MAX_CODE_BITS-1:0]       word_m;
  logic                           accept;
  logic                           sym_ok;
  logic [AW-1:0]                  idx;

  logic [MAX_CODE_BITS-1:0]       code_mem [SYMBOLS];
  logic [hcbp_pkg::LEN_W-1:0]     len_mem  [SYMBOLS];
  logic [SYMBOLS-1:0]             vld_r;

  logic [MAX_CODE_BITS-1:0]       rd_code_r;
  logic [hcbp_pkg::LEN_W-1:0]     rd_len_r;
  logic                           rd_vld_r;
  logic                           s1_valid_r, s1_valid_nxt;
  logic                           s1_flush_r;

  assign op     = in_tdata[1:0];
  assign sym    = in_tdata[9:2];
  assign word   = in_tdata[41:10];
  assign len_in = in_tdata[47:42];

  assign in_tready = q_stat.room2;
  assign accept    = in_tvalid && in_tready;
  assign sym_ok    = {1'b0, sym} < 9'(SYMBOLS);
  assign idx       = sym[AW-1:0];

  assign len_c = (len_in > hcbp_pkg::LEN_W'(MAX_CODE_BITS)) ?
                 hcbp_pkg::LEN_W'(MAX_CODE_BITS) : len_in;

  always_comb begin
    for (int i = 0; i < MAX_CODE_BITS; i++) begin
      word_m[i] = word[i] && (hcbp_pkg::LEN_W'(i) < len_c);
    end
  end

  // A flush does not depend on the symbol field.
  assign s1_valid_nxt = accept && (((op == hcbp_pkg::OP_ENCODE) && sym_ok) ||
                                   (op == hcbp_pkg::OP_FLUSH));

  // Table memories; a load and a later encode of the same entry are accepted at
  // separate edges, so the read sees the new contents.
  always_ff @(posedge clk) begin
    if (accept && (op == hcbp_pkg::OP_LOAD) && sym_ok) begin
      code_mem[idx] <= word_m;
      len_mem[idx]  <= len_c;
    end
    if (accept) begin
      rd_code_r  <= code_mem[idx];
      rd_len_r   <= len_mem[idx];
      rd_vld_r   <= vld_r[idx];
      s1_flush_r <= (op == hcbp_pkg::OP_FLUSH);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (accept && (op == hcbp_pkg::OP_LOAD) && sym_ok) begin
        vld_r[idx] <= 1'b1;
      end
    end
  end

  // Flushes always go to the queue; the back end drops them when empty.
  // An unloaded entry or a zero-length code has nothing to append.
  assign push = s1_valid_r &&
                (s1_flush_r || (rd_vld_r && (rd_len_r != '0)));

  assign push_cmd.is_flush = s1_flush_r;
  assign push_cmd.len      = rd_len_r;
  assign push_cmd.code     = hcbp_pkg::CODE_W'(rd_code_r);

endmodule

// ===== sv/hcbp_queue.sv =====
// Short command queue between the packer front end and back end.
// Uses hcbp_pkg for the command record and sizing.
module hcbp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hcbp_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output hcbp_pkg::cmd_t    pop_cmd,
  output hcbp_pkg::q_stat_t q_stat
);

  hcbp_pkg::cmd_t                mem_r [hcbp_pkg::QDEPTH];
  logic [hcbp_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [hcbp_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  assign pop_cmd      = mem_r[rd_ptr_r];
  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.room2 = (cnt_r <= hcbp_pkg::QCNT_W'(hcbp_pkg::QDEPTH - 2));

endmodule

// ===== sv/hcbp_back.sv =====
// Back end of the bit packer: appends codes to the bit accumulator and
// sends out one packed byte per cycle while out_tready allows. Uses hcbp_pkg for the command record.
module hcbp_back #(
  parameter int MAX_CODE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  hcbp_pkg::q_stat_t q_stat,
  input  hcbp_pkg::cmd_t    pop_cmd,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tlast
);

  localparam int ACC_W = MAX_CODE_BITS + hcbp_pkg::BYTE_BITS - 1;
  localparam int CNT_W = $clog2(ACC_W + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EMIT  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_data_r, out_data_nxt;
  logic             out_last_r, out_last_nxt;

  logic             out_free;
  logic [CNT_W-1:0] cnt_sum;
  logic [CNT_W-1:0] cnt_less8;
  logic [ACC_W-1:0] acc_shr;
  logic [3:0]       pad_sh;
  logic [7:0]       flush_byte;

  assign out_free  = !out_valid_r || out_tready;
  assign cnt_sum   = cnt_r + CNT_W'(pop_cmd.len);
  assign cnt_less8 = cnt_r - CNT_W'(hcbp_pkg::BYTE_BITS);
  assign acc_shr   = acc_r >> cnt_less8;
  // Only the low cnt_r bits of the accumulator are live; bits above them
  // are never selected.
  assign pad_sh     = 4'(hcbp_pkg::BYTE_BITS) - {1'b0, cnt_r[2:0]};
  assign flush_byte = acc_r[7:0] << pad_sh;

  assign pop = (state_r == ST_IDLE) && !q_stat.empty;

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          if (pop_cmd.is_flush) begin
            state_nxt = ST_FLUSH;
          end else begin
            acc_nxt = (acc_r << pop_cmd.len) | ACC_W'(pop_cmd.code);
            cnt_nxt = cnt_sum;
            if (cnt_sum >= CNT_W'(hcbp_pkg::BYTE_BITS)) begin
              state_nxt = ST_EMIT;
            end
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = acc_shr[7:0];
          out_last_nxt  = (cnt_less8 < CNT_W'(hcbp_pkg::BYTE_BITS));
          cnt_nxt       = cnt_less8;
          if (cnt_less8 < CNT_W'(hcbp_pkg::BYTE_BITS)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (cnt_r == '0) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = flush_byte;
          out_last_nxt  = 1'b1;
          cnt_nxt       = '0;
          acc_nxt       = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_idle_partial: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (cnt_r < CNT_W'(hcbp_pkg::BYTE_BITS)))
    else $error("bit count holds a whole byte while idle");

  a_emit_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (cnt_r >= CNT_W'(hcbp_pkg::BYTE_BITS)))
    else $error("emitting without a whole byte in the accumulator");

  a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (state_r == ST_EMIT))
    else $error("non-final byte shown with no further byte pending");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !pop)
    else $error("command taken while the packer is busy");
`endif

endmodule

// ===== sv/huffman_code_bit_packer_core.sv =====
// Top level of the Huffman code bit packer: front end with code tables,
// command queue and packing back end. Uses hcbp_pkg and the hcbp_* modules.
//
//  channel | direction | tdata fields (low bit up)                         | tlast
//  in_     | slave     | operation, symbol, code_word, code_length (48 b)  | -
//  out_    | master    | out_byte (8 b)                                    | last
//
// A word's table entry is read at the edge that accepts it and the command is
// queued in the next cycle. The packer takes one queued command per cycle when
// idle and sends one byte per cycle while out_tready allows; an encode word
// gives 0 to 4 bytes, a flush at most one byte, and a load is never queued.
// Reset (rst_n low at a clock edge) marks all table entries unloaded and
// empties the accumulator and queue. Output stalls back up through the queue.
module huffman_code_bit_packer_core #(
  parameter int SYMBOLS       = 256,
  parameter int MAX_CODE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // operation[1:0], symbol[9:2], code_word[41:10],
                                  // code_length[47:42]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte[7:0]
  output logic        out_tlast
);

  hcbp_pkg::q_stat_t q_stat;
  hcbp_pkg::cmd_t    push_cmd;
  hcbp_pkg::cmd_t    pop_cmd;
  logic              push;
  logic              pop;

  hcbp_front #(
    .SYMBOLS       (SYMBOLS),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  hcbp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_stat   (q_stat)
  );

  hcbp_back #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .pop_cmd    (pop_cmd),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
